FILE: rtl/core/stld_pkg.sv
// Shared types and constants for the sync/type/length deframer.
package stld_pkg;

    // Sync pattern and the range of known packet types
    localparam logic [7:0] SYNC_FIRST  = 8'h24;  // '$'
    localparam logic [7:0] SYNC_SECOND = 8'h50;  // 'P'
    localparam logic [7:0] SYNC_THIRD  = 8'h3E;  // '>'
    localparam logic [7:0] KNOWN_LOW   = 8'd65;
    localparam logic [7:0] KNOWN_HIGH  = 8'd70;

    // Parse phases
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SECOND  = 3'd1,
        PH_THIRD   = 3'd2,
        PH_TYPE    = 3'd3,
        PH_LENGTH  = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    // One result transaction
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] packet_type;
        logic [7:0] payload_index;
        logic       last_byte;
        logic       type_known;
    } result_t;

endpackage

FILE: rtl/core/sync_type_length_deframer_core.sv
// Byte-serial deframer: sync hunt, type and length header, payload output.
//
//  channel | direction | ports                                    | handshake
//  s_      | in        | s_rx_byte                                | s_valid / s_ready
//  m_      | out       | m_payload_byte, m_packet_type,           | m_valid / m_ready
//          |           | m_payload_index, m_last_byte, m_type_known
//
// One byte per cycle is accepted while s_ready is high; m_ outputs are registered.
// The parse state is a single register stage updated on each accepted byte.
// A two-entry output (result register plus skid register) keeps s_ready high
// while one result waits; s_ready drops only when both entries are full.
// aresetn is synchronous, active low, and returns the parser to the hunt.
module sync_type_length_deframer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_packet_type,
    output logic [7:0] m_payload_index,
    output logic       m_last_byte,
    output logic       m_type_known
);
    import stld_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg, count_next;

    result_t    out_reg, skid_reg, result;
    logic       out_valid_reg, skid_valid_reg;

    logic       accept;
    logic       produce;
    logic [7:0] count_inc;
    logic       is_last;

    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign count_inc = count_reg + 8'd1;
    assign is_last   = (count_inc == length_reg);
    assign produce   = accept && (phase_reg == PH_PAYLOAD);

    // Next parse state
    always_comb begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        length_next = length_reg;
        count_next  = count_reg;
        if (accept) begin
            case (phase_reg)
                PH_SECOND: phase_next = (s_rx_byte == SYNC_SECOND) ? PH_THIRD : PH_HUNT;
                PH_THIRD:  phase_next = (s_rx_byte == SYNC_THIRD) ? PH_TYPE : PH_HUNT;
                PH_TYPE: begin
                    type_next  = s_rx_byte;
                    phase_next = PH_LENGTH;
                end
                PH_LENGTH: begin
                    length_next = s_rx_byte;
                    count_next  = 8'd0;
                    phase_next  = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    count_next = count_inc;
                    if (is_last) begin
                        phase_next = PH_HUNT;
                    end
                end
                default:   phase_next = (s_rx_byte == SYNC_FIRST) ? PH_SECOND : PH_HUNT;
            endcase
        end
    end

    // Result for the byte being accepted
    always_comb begin
        result.payload_byte  = s_rx_byte;
        result.packet_type   = type_reg;
        result.payload_index = count_reg;
        result.last_byte     = is_last;
        result.type_known    = (type_reg >= KNOWN_LOW) && (type_reg <= KNOWN_HIGH);
    end

    // Parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            type_reg   <= 8'd0;
            length_reg <= 8'd0;
            count_reg  <= 8'd0;
        end else begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

    // Output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end else begin
                out_valid_reg <= produce;
                if (produce) begin
                    out_reg <= result;
                end
            end
        end else if (produce) begin
            skid_reg       <= result;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_packet_type   = out_reg.packet_type;
    assign m_payload_index = out_reg.payload_index;
    assign m_last_byte     = out_reg.last_byte;
    assign m_type_known    = out_reg.type_known;

`ifndef SYNTHESIS
    // The skid entry is only ever filled behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // A stalled result is never dropped
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg)
        else $error("stalled result lost");

    // Payload bytes that are not last advance the index by one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && !is_last) |=> (count_reg == $past(count_inc)) && (phase_reg == PH_PAYLOAD))
        else $error("payload index did not advance");

    // A start byte in the hunt moves on to the second sync byte
    a_hunt_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_HUNT && s_rx_byte == SYNC_FIRST) |=> (phase_reg == PH_SECOND))
        else $error("start byte not taken");
`endif

endmodule
